### rtl/rbe_pkg.sv
// rbe_pkg: shared types, sizes and register codes of the region boundary extractor
// no dependencies
`timescale 1ns / 1ps

package rbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int PIX_W  = 10;
  localparam int CODE_W = 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_TARGET   = 2'd0;
  localparam logic [1:0] REG_INTERIOR = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             border_cell;
    logic             last;
  } out_item_t;

  // clamped, ready-to-use configuration
  typedef struct packed {
    logic [CODE_W-1:0] target_code;
    logic              emit_interior;
    logic [XW:0]       width;
    logic [YW:0]       height;
  } cfg_t;

endpackage

### rtl/rbe_ram.sv
// rbe_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rbe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rbe_cfg.sv
// rbe_cfg: apb register file, clamps the frame size for the datapath
// depends on rbe_pkg
`timescale 1ns / 1ps

module rbe_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbe_pkg::ADDR_W-1:0] paddr,
  input  logic [rbe_pkg::DATA_W-1:0] pwdata,
  output logic [rbe_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rbe_pkg::cfg_t              cfg_o
);

  logic [rbe_pkg::CODE_W-1:0] target_q;
  logic                       interior_q;
  logic [rbe_pkg::SIZE_W-1:0] width_q;
  logic [rbe_pkg::SIZE_W-1:0] height_q;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= rbe_pkg::CODE_W'(1);
      interior_q <= 1'b0;
      width_q    <= rbe_pkg::SIZE_W'(1024);
      height_q   <= rbe_pkg::SIZE_W'(1024);
    end else if (wr_en) begin
      case (reg_idx)
        rbe_pkg::REG_TARGET:   target_q   <= pwdata[rbe_pkg::CODE_W-1:0];
        rbe_pkg::REG_INTERIOR: interior_q <= pwdata[0];
        rbe_pkg::REG_WIDTH:    width_q    <= pwdata[rbe_pkg::SIZE_W-1:0];
        rbe_pkg::REG_HEIGHT:   height_q   <= pwdata[rbe_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rbe_pkg::REG_TARGET:   prdata = rbe_pkg::DATA_W'(target_q);
      rbe_pkg::REG_INTERIOR: prdata = rbe_pkg::DATA_W'(interior_q);
      rbe_pkg::REG_WIDTH:    prdata = rbe_pkg::DATA_W'(width_q);
      rbe_pkg::REG_HEIGHT:   prdata = rbe_pkg::DATA_W'(height_q);
      default:               prdata = '0;
    endcase
  end

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    cfg_o.target_code   = target_q;
    cfg_o.emit_interior = interior_q;
    if (width_q == '0) begin
      cfg_o.width = (rbe_pkg::XW+1)'(1);
    end else if (32'(width_q) > 32'(rbe_pkg::MAX_WIDTH)) begin
      cfg_o.width = (rbe_pkg::XW+1)'(rbe_pkg::MAX_WIDTH);
    end else begin
      cfg_o.width = (rbe_pkg::XW+1)'(width_q);
    end
    if (height_q == '0) begin
      cfg_o.height = (rbe_pkg::YW+1)'(1);
    end else if (32'(height_q) > 32'(rbe_pkg::MAX_HEIGHT)) begin
      cfg_o.height = (rbe_pkg::YW+1)'(rbe_pkg::MAX_HEIGHT);
    end else begin
      cfg_o.height = (rbe_pkg::YW+1)'(height_q);
    end
  end

endmodule

### rtl/rbe_out_buf.sv
// rbe_out_buf: two-entry result queue taking up to two results per cycle
// depends on rbe_pkg
`timescale 1ns / 1ps

module rbe_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  rbe_pkg::out_item_t push_a_i,
  input  rbe_pkg::out_item_t push_b_i,
  output logic [1:0]         room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbe_pkg::out_item_t out_data_o
);

  rbe_pkg::out_item_t ent_q [2];
  rbe_pkg::out_item_t ent_d [2];
  logic [1:0]         cnt_q;
  logic [1:0]         cnt_d;
  logic [1:0]         base;
  logic               pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign base        = cnt_q - {1'b0, pop};
  assign room_o      = 2'd2 - base;

  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (push_n_i != 2'd0) begin
      ent_d[base[0]] = push_a_i;
    end
    if (push_n_i == 2'd2) begin
      ent_d[1] = push_b_i;
    end
    cnt_d = base + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

### rtl/region_boundary_extract.sv
// region_boundary_extract: top level, position counters, column store and 3x3 decision
// depends on rbe_pkg, rbe_ram, rbe_cfg, rbe_out_buf
//
//   port group   direction   carries
//   in_*         sink        one grid cell per transfer (in_item_t)
//   out_*        source      one reported cell per transfer (out_item_t)
//   apb          slave       four configuration registers at 0x0, 0x4, 0x8, 0xc
//
// a cell is accepted every cycle while results drain; the column store read is
// issued at acceptance and the decision is made in the cycle after, when the ram data
// arrives. a cell giving two results can hold the next cell back at the two-entry
// result queue. a result passes the decision stage and then the result queue before
// it is offered. reset clears counters and window bits; the column store needs no
// clearing pass. a stalled result queue stops acceptance once its room runs out.
`timescale 1ns / 1ps

module region_boundary_extract (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rbe_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rbe_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbe_pkg::ADDR_W-1:0] paddr,
  input  logic [rbe_pkg::DATA_W-1:0] pwdata,
  output logic [rbe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  rbe_pkg::cfg_t cfg;

  logic [rbe_pkg::XW-1:0] col_q, col_d;
  logic [rbe_pkg::YW-1:0] row_q, row_d;
  logic                   s1_valid_q;
  logic                   s1_m_q;
  logic [rbe_pkg::XW-1:0] s1_x_q;
  logic [rbe_pkg::YW-1:0] s1_y_q;
  logic [3:0]             win_q;
  logic [1:0]             cur_q;
  logic                   fwd_q;
  logic [1:0]             fwd_data_q;

  logic                   accept;
  logic                   restart;
  logic [rbe_pkg::XW-1:0] x_new;
  logic [rbe_pkg::YW-1:0] y_new;
  logic                   m_new;
  logic [rbe_pkg::YW:0]   row_inc;
  logic [rbe_pkg::XW:0]   col_inc;

  logic [1:0]             rdata;
  logic [1:0]             pair;
  logic [3:0]             wb;
  logic [1:0]             cc;
  logic                   nine_all;
  logic                   delay_hit;
  logic                   delay_res;
  logic                   edge_res;
  logic [1:0]             n_res;
  logic [1:0]             room;
  logic                   s1_fire;
  logic [1:0]             wdata;
  rbe_pkg::out_item_t     res_delay;
  rbe_pkg::out_item_t     res_edge;
  rbe_pkg::out_item_t     push_a;
  rbe_pkg::out_item_t     push_b;

  rbe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // position of the arriving cell
  assign restart = in_data_i.frame_start
                || ({1'b0, col_q} >= cfg.width)
                || ({1'b0, row_q} >= cfg.height);
  assign x_new   = restart ? '0 : col_q;
  assign y_new   = restart ? '0 : row_q;
  assign m_new   = (in_data_i.cell_code == cfg.target_code);
  assign row_inc = {1'b0, y_new} + (rbe_pkg::YW+1)'(1);
  assign col_inc = {1'b0, x_new} + (rbe_pkg::XW+1)'(1);

  always_comb begin
    row_d = row_inc[rbe_pkg::YW-1:0];
    col_d = x_new;
    if (row_inc >= cfg.height) begin
      row_d = '0;
      col_d = (col_inc >= cfg.width) ? '0 : col_inc[rbe_pkg::XW-1:0];
    end
  end

  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  rbe_ram #(
    .WIDTH (2),
    .DEPTH (rbe_pkg::MAX_HEIGHT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_y_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (y_new),
    .rdata_o (rdata)
  );

  // decision stage
  assign pair = fwd_q ? fwd_data_q : rdata;
  assign wb   = (s1_y_q == '0) ? 4'd0 : win_q;
  assign cc   = (s1_y_q == '0) ? 2'd0 : cur_q;

  assign nine_all  = s1_m_q && (pair == 2'b11) && cc[0] && cc[1]
                  && (wb[1:0] == 2'b11) && (wb[3:2] == 2'b11);
  assign delay_hit = (s1_x_q >= rbe_pkg::XW'(2)) && (s1_y_q >= rbe_pkg::YW'(2)) && wb[0];
  assign delay_res = delay_hit && (!nine_all || cfg.emit_interior);
  assign edge_res  = s1_m_q && ((s1_x_q == '0) || (s1_y_q == '0)
                  || ({1'b0, s1_x_q} == cfg.width - (rbe_pkg::XW+1)'(1))
                  || ({1'b0, s1_y_q} == cfg.height - (rbe_pkg::YW+1)'(1)));
  assign n_res     = {1'b0, delay_res} + {1'b0, edge_res};
  assign s1_fire   = s1_valid_q && (n_res <= room);
  assign wdata     = {pair[0], s1_m_q};

  always_comb begin
    res_delay.pixel_x     = rbe_pkg::PIX_W'(s1_x_q - rbe_pkg::XW'(1));
    res_delay.pixel_y     = rbe_pkg::PIX_W'(s1_y_q - rbe_pkg::YW'(1));
    res_delay.border_cell = !nine_all;
    res_delay.last        = !edge_res;
    res_edge.pixel_x      = rbe_pkg::PIX_W'(s1_x_q);
    res_edge.pixel_y      = rbe_pkg::PIX_W'(s1_y_q);
    res_edge.border_cell  = 1'b1;
    res_edge.last         = 1'b1;
    push_a                = delay_res ? res_delay : res_edge;
    push_b                = res_edge;
  end

  rbe_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (s1_fire ? n_res : 2'd0),
    .push_a_i    (push_a),
    .push_b_i    (push_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
      cur_q      <= '0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s1_fire) begin
        win_q <= {wb[1:0], pair};
        cur_q <= {cc[0], s1_m_q};
      end
      s1_valid_q <= accept || (s1_valid_q && !s1_fire);
      // read and write of the same row at one edge: ram returns stale data
      if (accept) begin
        fwd_q <= s1_fire && (y_new == s1_y_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_m_q     <= m_new;
      s1_x_q     <= x_new;
      s1_y_q     <= y_new;
      fwd_data_q <= wdata;
    end
  end

endmodule

### rtl/rbe_checker.sv
// rbe_checker: port-level assertions for region_boundary_extract, bound to the top
// depends on rbe_pkg
`timescale 1ns / 1ps

module rbe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rbe_pkg::out_item_t out_data_o
);

  // a result waiting is held unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // the second result of a cell is already queued behind the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("second result of a cell missing");

  // a non-final result is always a delayed inner cell
  a_first_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.pixel_x != '0 && out_data_o.pixel_y != '0)
    else $error("non-final result on the frame edge");

  // input backpressure only comes from pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind region_boundary_extract rbe_checker u_rbe_checker (.*);

### dv/region_boundary_extract_tb.sv
// region_boundary_extract_tb: self-checking testbench for the region boundary extractor
// streams grids of cell codes, predicts every reported cell and checks each output transfer
// depends on rbe_pkg and region_boundary_extract
`timescale 1ns / 1ps

module region_boundary_extract_tb;

  localparam logic [rbe_pkg::CODE_W-1:0] CELL_UNSET       = 2'd0;
  localparam logic [rbe_pkg::CODE_W-1:0] CELL_DESIRED     = 2'd1;
  localparam logic [rbe_pkg::CODE_W-1:0] CELL_OVERPAINT   = 2'd2;
  localparam logic [rbe_pkg::CODE_W-1:0] CELL_UNTOUCHABLE = 2'd3;

  class boundary_sb;
    logic [rbe_pkg::CODE_W-1:0] region_code;
    bit                         emit_inner;
    logic [rbe_pkg::SIZE_W-1:0] cols_reg;
    logic [rbe_pkg::SIZE_W-1:0] rows_reg;
    bit [1:0]                   col_history [rbe_pkg::MAX_HEIGHT];
    bit [3:0]                   above_pairs;
    bit [1:0]                   above_bits;
    int                         col_pos;
    int                         row_pos;
    rbe_pkg::out_item_t         due_reports [$];
    int                         faults;
    int                         cells_seen;

    function new();
      region_code = CELL_DESIRED;
      emit_inner  = 1'b0;
      cols_reg    = 11'd1024;
      rows_reg    = 11'd1024;
      foreach (col_history[i]) col_history[i] = 2'b00;
      above_pairs = '0;
      above_bits  = '0;
      col_pos     = 0;
      row_pos     = 0;
      faults      = 0;
      cells_seen  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [rbe_pkg::DATA_W-1:0] v);
      case (idx)
        rbe_pkg::REG_TARGET:   region_code = v[rbe_pkg::CODE_W-1:0];
        rbe_pkg::REG_INTERIOR: emit_inner  = v[0];
        rbe_pkg::REG_WIDTH:    cols_reg    = v[rbe_pkg::SIZE_W-1:0];
        rbe_pkg::REG_HEIGHT:   rows_reg    = v[rbe_pkg::SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function int fit_size(logic [rbe_pkg::SIZE_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
    endfunction

    function rbe_pkg::out_item_t report(int x, int y, bit on_edge);
      rbe_pkg::out_item_t r;
      r.pixel_x     = x[rbe_pkg::PIX_W-1:0];
      r.pixel_y     = y[rbe_pkg::PIX_W-1:0];
      r.border_cell = on_edge;
      r.last        = 1'b0;
      return r;
    endfunction

    function void take_cell(rbe_pkg::in_item_t c);
      int                 w, h, x, y, n, k;
      bit                 m;
      bit [1:0]           pair;
      bit [8:0]           nine;
      rbe_pkg::out_item_t res [2];
      w = fit_size(cols_reg, rbe_pkg::MAX_WIDTH);
      h = fit_size(rows_reg, rbe_pkg::MAX_HEIGHT);
      m = (c.cell_code == region_code);
      n = 0;
      cells_seen++;
      if (c.frame_start || col_pos >= w || row_pos >= h) begin
        col_pos = 0;
        row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      if (y == 0) begin
        above_pairs = '0;
        above_bits  = '0;
      end
      pair = col_history[y];
      // inner cell up and left of this one is decided now
      if (x >= 2 && y >= 2 && above_pairs[0]) begin
        nine = {above_pairs[3:2], above_bits[1], above_pairs[1:0], above_bits[0], pair, m};
        if (!(&nine)) begin
          res[n] = report(x - 1, y - 1, 1'b1);
          n++;
        end else if (emit_inner) begin
          res[n] = report(x - 1, y - 1, 1'b0);
          n++;
        end
      end
      if (m && (x == 0 || y == 0 || x == w - 1 || y == h - 1)) begin
        res[n] = report(x, y, 1'b1);
        n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (k = 0; k < n; k++) due_reports = {due_reports, res[k]};
      col_history[y] = {pair[0], m};
      above_bits     = {above_bits[0], m};
      above_pairs    = {above_pairs[1:0], pair};
      row_pos = y + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        col_pos = x + 1;
        if (col_pos >= w) col_pos = 0;
      end
    endfunction

    function void take_result(rbe_pkg::out_item_t got);
      rbe_pkg::out_item_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected result: pixel_x %0d pixel_y %0d", got.pixel_x, got.pixel_y);
        faults++;
        return;
      end
      want = due_reports.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, actual %0d", want.pixel_x, got.pixel_x);
        faults++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, actual %0d", want.pixel_y, got.pixel_y);
        faults++;
      end
      if (got.border_cell !== want.border_cell) begin
        $error("border_cell: expected %0b, actual %0b", want.border_cell, got.border_cell);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  rbe_pkg::in_item_t          in_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  rbe_pkg::out_item_t         out_data_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rbe_pkg::ADDR_W-1:0] paddr;
  logic [rbe_pkg::DATA_W-1:0] pwdata;
  logic [rbe_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  boundary_sb sb = new();
  int         burst_left;

  region_boundary_extract uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_cell(in_data_i);
      if (out_valid_o && out_ready_i) sb.take_result(out_data_o);
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [rbe_pkg::DATA_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic wait_drained();
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_cells(int n, logic [rbe_pkg::CODE_W-1:0] target, int density,
                            bit fresh, bit noisy);
    rbe_pkg::in_item_t c;
    int                i;
    int                gap;
    for (i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk_i);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
      end
      c.cell_code   = ($urandom_range(0, 99) < density) ? target
                                                        : rbe_pkg::CODE_W'($urandom_range(0, 3));
      c.frame_start = (i == 0 && fresh) || (noisy && $urandom_range(0, 199) == 0);
      in_valid_i <= 1'b1;
      in_data_i  <= c;
      do @(posedge clk_i); while (!in_ready_o);
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [rbe_pkg::CODE_W-1:0] target, bit inner, int w, int h,
                           int n, int density, bit fresh, bit noisy);
    wait_drained();
    apb_write(rbe_pkg::REG_TARGET, rbe_pkg::DATA_W'(target));
    apb_write(rbe_pkg::REG_INTERIOR, rbe_pkg::DATA_W'(inner));
    apb_write(rbe_pkg::REG_WIDTH, rbe_pkg::DATA_W'(w));
    apb_write(rbe_pkg::REG_HEIGHT, rbe_pkg::DATA_W'(h));
    send_cells(n, target, density, fresh, noisy);
  endtask

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int run;
    int mode;
    bit held;
    out_ready_i = 1'b0;
    held        = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && sb.cells_seen >= 100) begin
        held = 1'b1;
        repeat (400) begin
          @(posedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
      run  = $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_cells;
    int w;
    int h;
    int n;
    int density;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // solid 3x3 region: one interior cell
    run_phase(CELL_OVERPAINT, 1'b1, 3, 3, 9, 100, 1'b1, 1'b0);
    // mixed codes, stops mid-grid at column 1 row 2
    run_phase(CELL_UNTOUCHABLE, 1'b0, 4, 4, 6, 25, 1'b1, 1'b0);
    // height shrinks below current row: next cell restarts the grid
    run_phase(CELL_UNSET, 1'b1, 4, 2, 3, 60, 1'b0, 1'b0);
    // zero sizes count as a 1x1 grid
    run_phase(CELL_DESIRED, 1'b0, 0, 0, 2, 100, 1'b1, 1'b0);

    // wide and tall strips reach the high coordinate bits, sizes above max clamp
    phase_cells = 0;
    run_phase(rbe_pkg::CODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              2047, 1, 520, 60, 1'b1, 1'b1);
    phase_cells += 520;
    run_phase(rbe_pkg::CODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1, 1500, 520, 60, 1'b1, 1'b1);
    phase_cells += 520;
    run_phase(rbe_pkg::CODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1024, 2, 60, 80, 1'b1, 1'b1);
    phase_cells += 60;
    while (phase_cells < 1650) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      n = w * h * $urandom_range(2, 4) + $urandom_range(0, w * h);
      if (n > 250) n = 250;
      case ($urandom_range(0, 3))
        0:       density = 100;
        1:       density = 90;
        2:       density = 75;
        default: density = 40;
      endcase
      run_phase(rbe_pkg::CODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                w, h, n, density, 1'b1, 1'b1);
      phase_cells += n;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.faults == 0 && sb.due_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/rbe_pkg.sv
rtl/rbe_ram.sv
rtl/rbe_cfg.sv
rtl/rbe_out_buf.sv
rtl/region_boundary_extract.sv
rtl/rbe_checker.sv
dv/region_boundary_extract_tb.sv
